### sv/deq_pkg.sv
package deq_pkg;

  // Command codes
  localparam logic [2:0] CMD_PUSH_FRONT = 3'd0;
  localparam logic [2:0] CMD_PUSH_BACK  = 3'd1;
  localparam logic [2:0] CMD_POP_FRONT  = 3'd2;
  localparam logic [2:0] CMD_POP_BACK   = 3'd3;
  localparam logic [2:0] CMD_REMOVE     = 3'd4;
  localparam logic [2:0] CMD_CLEAR      = 3'd5;

  // Result status codes
  localparam logic [1:0] ST_OK        = 2'd0;
  localparam logic [1:0] ST_EMPTY     = 2'd1;
  localparam logic [1:0] ST_NOT_FOUND = 2'd2;
  localparam logic [1:0] ST_FULL      = 2'd3;

  // Contents of one cell as seen by its neighbours
  typedef struct packed {
    logic        valid;
    logic [31:0] value;
  } cell_link_t;

  // Broadcast control for the whole row
  typedef struct packed {
    logic        en;
    logic [2:0]  cmd;
    logic [31:0] value;
  } cell_ctl_t;

  // Front-to-back ripple: has an earlier cell been selected, and its value
  typedef struct packed {
    logic        found;
    logic [31:0] taken;
  } cell_fwd_t;

endpackage

### sv/deq_cell.sv
module deq_cell
  import deq_pkg::*;
(
  input  logic       clk_i,
  input  logic       rst_ni,
  input  cell_ctl_t  ctl_i,
  input  cell_link_t prev_i,
  input  cell_link_t next_i,
  input  cell_fwd_t  fwd_i,
  output cell_fwd_t  fwd_o,
  output cell_link_t state_o
);

  logic        valid_q, valid_d;
  logic [31:0] value_q, value_d;
  logic        hit, sel, shift;

  // Selection of the cell that gives up its element
  always_comb begin
    hit = 1'b0;
    if (ctl_i.en) begin
      case (ctl_i.cmd)
        CMD_POP_FRONT: hit = valid_q;
        CMD_POP_BACK:  hit = valid_q & ~next_i.valid;
        CMD_REMOVE:    hit = valid_q & (value_q == ctl_i.value);
        default:       hit = 1'b0;
      endcase
    end
    sel   = hit & ~fwd_i.found;
    shift = hit | fwd_i.found;
  end

  assign fwd_o.found = fwd_i.found | hit;
  assign fwd_o.taken = fwd_i.taken | (sel ? value_q : 32'd0);

  // Next contents: take from a neighbour, the input value, empty the cell, or hold
  always_comb begin
    valid_d = valid_q;
    value_d = value_q;
    if (ctl_i.en) begin
      case (ctl_i.cmd)
        CMD_PUSH_FRONT: begin
          valid_d = prev_i.valid;
          value_d = prev_i.value;
        end
        CMD_PUSH_BACK: begin
          if (!valid_q && prev_i.valid) begin
            valid_d = 1'b1;
            value_d = ctl_i.value;
          end
        end
        CMD_POP_FRONT, CMD_REMOVE: begin
          if (shift) begin
            valid_d = next_i.valid;
            value_d = next_i.value;
          end
        end
        CMD_POP_BACK: valid_d = valid_q & next_i.valid;
        CMD_CLEAR:    valid_d = 1'b0;
        default: ;
      endcase
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      valid_q <= 1'b0;
    end else begin
      valid_q <= valid_d;
    end
  end

  // Element storage, no reset
  always_ff @(posedge clk_i) begin
    value_q <= value_d;
  end

  assign state_o.valid = valid_q;
  assign state_o.value = value_q;

endmodule

### sv/double_ended_queue.sv
// Result: each taken command has its result registered on the outputs, with done_o high,
//   in the cycle after it is taken.
// Throughput: one command per cycle; busy_o stays low, the whole cell row shifts together.
// Reset: asynchronous, active low; all cells empty, count zero, no result pending.
// Results cannot be stalled by the receiver.
module double_ended_queue
  import deq_pkg::*;
#(
  parameter int CAPACITY = 16
) (
  input  logic               clk_i,
  input  logic               rst_ni,
  input  logic               start_i,
  output logic               busy_o,
  input  logic [2:0]         command_i,
  input  logic signed [31:0] value_i,
  output logic               done_o,
  output logic [1:0]         status_o,
  output logic signed [31:0] removed_value_o,
  output logic [4:0]         count_o
);

  localparam int CW = $clog2(CAPACITY + 1);

  cell_ctl_t  ctl;
  cell_link_t state [CAPACITY];
  cell_link_t prev  [CAPACITY];
  cell_link_t next  [CAPACITY];
  cell_fwd_t  fwd   [CAPACITY+1];

  logic          accept, full, empty, found;
  logic [CW-1:0] count_q, count_d;
  logic          done_q;
  logic [1:0]    status_q, status_d;
  logic [31:0]   removed_q, removed_d;

  assign busy_o = 1'b0;
  assign accept = start_i & ~busy_o;
  assign full   = state[CAPACITY-1].valid;
  assign empty  = ~state[0].valid;
  assign found  = fwd[CAPACITY].found;

  // Row control: pushes into a full row and spare codes are not broadcast
  always_comb begin
    ctl.en    = accept;
    ctl.cmd   = command_i;
    ctl.value = value_i;
    case (command_i)
      CMD_PUSH_FRONT, CMD_PUSH_BACK: begin
        if (full) ctl.en = 1'b0;
      end
      CMD_POP_FRONT, CMD_POP_BACK, CMD_REMOVE, CMD_CLEAR: ;
      default: ctl.en = 1'b0;
    endcase
  end

  // Status and next count
  always_comb begin
    status_d  = ST_OK;
    count_d   = count_q;
    case (command_i)
      CMD_PUSH_FRONT, CMD_PUSH_BACK: begin
        if (full) begin
          status_d = ST_FULL;
        end else begin
          count_d = count_q + CW'(1);
        end
      end
      CMD_POP_FRONT, CMD_POP_BACK: begin
        if (empty) status_d = ST_EMPTY;
        else count_d = count_q - CW'(1);
      end
      CMD_REMOVE: begin
        if (found) count_d = count_q - CW'(1);
        else status_d = ST_NOT_FOUND;
      end
      CMD_CLEAR: count_d = '0;
      default: ;
    endcase
    removed_d = fwd[CAPACITY].taken;
  end

  // Neighbour wiring: the front cell sees the pushed item, the back cell an empty slot
  assign fwd[0].found = 1'b0;
  assign fwd[0].taken = 32'd0;

  for (genvar i = 0; i < CAPACITY; i++) begin : g_cell
    if (i == 0) begin : g_front
      assign prev[i].valid = 1'b1;
      assign prev[i].value = value_i;
    end else begin : g_mid_prev
      assign prev[i] = state[i-1];
    end
    if (i == CAPACITY - 1) begin : g_back
      assign next[i].valid = 1'b0;
      assign next[i].value = 32'd0;
    end else begin : g_mid_next
      assign next[i] = state[i+1];
    end

    deq_cell u_cell (
      .clk_i   (clk_i),
      .rst_ni  (rst_ni),
      .ctl_i   (ctl),
      .prev_i  (prev[i]),
      .next_i  (next[i]),
      .fwd_i   (fwd[i]),
      .fwd_o   (fwd[i+1]),
      .state_o (state[i])
    );
  end

  // Count and result registers
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      count_q <= '0;
      done_q  <= 1'b0;
    end else begin
      done_q <= accept;
      if (accept) begin
        count_q <= count_d;
      end
    end
  end

  always_ff @(posedge clk_i) begin
    if (accept) begin
      status_q  <= status_d;
      removed_q <= removed_d;
    end
  end

  assign done_o          = done_q;
  assign status_o        = status_q;
  assign removed_value_o = removed_q;
  assign count_o         = 5'(count_q);

endmodule

### sv/deq_checker.sv
module deq_checker
  import deq_pkg::*;
(
  input logic               clk_i,
  input logic               rst_ni,
  input logic               start_i,
  input logic               busy_o,
  input logic [2:0]         command_i,
  input logic               done_o,
  input logic [1:0]         status_o,
  input logic signed [31:0] removed_value_o,
  input logic [4:0]         count_o
);

  // Every result answers an item taken in the previous cycle
  a_done_follows_accept: assert property (@(posedge clk_i) disable iff (!rst_ni)
    done_o |-> $past(start_i && !busy_o))
    else $error("result without an accepted item");

  // Failed commands hand out no element
  a_fail_no_value: assert property (@(posedge clk_i) disable iff (!rst_ni)
    (done_o && status_o != ST_OK) |-> removed_value_o == 32'sd0)
    else $error("value returned on a failed command");

  // A pop that finds the queue empty leaves it empty
  a_empty_count: assert property (@(posedge clk_i) disable iff (!rst_ni)
    (done_o && status_o == ST_EMPTY) |-> count_o == 5'd0)
    else $error("empty status with elements held");

  // Clear always leaves nothing behind
  a_clear_count: assert property (@(posedge clk_i) disable iff (!rst_ni)
    (done_o && $past(command_i) == CMD_CLEAR) |-> (count_o == 5'd0 && status_o == ST_OK))
    else $error("clear left elements");

endmodule

bind double_ended_queue deq_checker u_deq_checker (.*);

### tb/deque_checker.sv
`timescale 1ns / 100ps

// Watches the command and result ports of the deque, keeps its own copy of
// the held elements and checks every result against the predicted one.
module deque_checker
  import deq_pkg::*;
#(
  parameter int CAPACITY = 16
) (
  input  logic               clk_i,
  input  logic               rst_ni,
  input  logic               start_i,
  input  logic               busy_o,
  input  logic [2:0]         command_i,
  input  logic signed [31:0] value_i,
  input  logic               done_o,
  input  logic [1:0]         status_o,
  input  logic signed [31:0] removed_value_o,
  input  logic [4:0]         count_o,
  output int                 fail_count_o,
  output int                 pending_o,
  output int                 checked_o,
  output int                 full_hits_o,
  output int                 empty_hits_o,
  output int                 miss_hits_o
);

  typedef struct packed {
    logic [1:0]         status;
    logic signed [31:0] removed_value;
    logic [4:0]         count;
  } deq_result_t;

  // Elements held, front of the deque at index 0
  logic signed [31:0] held_values[$];
  // Results still owed by the block, oldest first
  deq_result_t        owed_results[$];

  // Apply one command to the held elements and work out its result
  function automatic deq_result_t apply_command(input logic [2:0] cmd,
                                                input logic signed [31:0] val);
    deq_result_t res;
    int          hit;
    res.status        = ST_OK;
    res.removed_value = '0;
    hit               = -1;
    case (cmd)
      CMD_PUSH_FRONT: begin
        if (held_values.size() >= CAPACITY) res.status = ST_FULL;
        else held_values.push_front(val);
      end
      CMD_PUSH_BACK: begin
        if (held_values.size() >= CAPACITY) res.status = ST_FULL;
        else held_values.push_back(val);
      end
      CMD_POP_FRONT: begin
        if (held_values.size() == 0) res.status = ST_EMPTY;
        else res.removed_value = held_values.pop_front();
      end
      CMD_POP_BACK: begin
        if (held_values.size() == 0) res.status = ST_EMPTY;
        else res.removed_value = held_values.pop_back();
      end
      CMD_REMOVE: begin
        // first match from the front goes
        foreach (held_values[i]) begin
          if (hit < 0 && held_values[i] == val) hit = i;
        end
        if (hit < 0) begin
          res.status = ST_NOT_FOUND;
        end else begin
          res.removed_value = held_values[hit];
          held_values.delete(hit);
        end
      end
      CMD_CLEAR: held_values.delete();
      default: ;  // spare codes leave everything as it is
    endcase
    res.count = 5'(held_values.size());
    return res;
  endfunction

  // Score results, then predict for a command taken at the same edge
  always @(posedge clk_i or negedge rst_ni) begin : score
    deq_result_t owed;
    if (!rst_ni) begin
      held_values.delete();
      owed_results.delete();
      pending_o <= 0;
    end else begin
      if (done_o) begin
        if (owed_results.size() == 0) begin
          $error("result with no command outstanding: status %0d removed_value %0d count %0d",
                 status_o, removed_value_o, count_o);
          fail_count_o++;
        end else begin
          owed = owed_results.pop_front();
          checked_o++;
          if (status_o !== owed.status) begin
            $error("status: expected %0d, got %0d", owed.status, status_o);
            fail_count_o++;
          end
          if (removed_value_o !== owed.removed_value) begin
            $error("removed_value: expected %0d, got %0d",
                   $signed(owed.removed_value), removed_value_o);
            fail_count_o++;
          end
          if (count_o !== owed.count) begin
            $error("count: expected %0d, got %0d", owed.count, count_o);
            fail_count_o++;
          end
        end
      end
      if (start_i && !busy_o) begin
        owed = apply_command(command_i, value_i);
        case (owed.status)
          ST_FULL:      full_hits_o++;
          ST_EMPTY:     empty_hits_o++;
          ST_NOT_FOUND: miss_hits_o++;
          default: ;
        endcase
        owed_results.push_back(owed);
      end
      pending_o <= owed_results.size();
    end
  end

endmodule

### tb/double_ended_queue_tb.sv
`timescale 1ns / 100ps

// Drives command items into the deque in bursts and gives the verdict;
// prediction and checking sit in the checker beside the block.
module double_ended_queue_tb;
  import deq_pkg::*;

  localparam int CAPACITY    = 16;
  localparam int ITEM_TARGET = 800;
  localparam int STALL_LIMIT = 1000;
  localparam int TAIL_CYCLES = 4;
  localparam int DRAIN_EVERY = 200;

  // Codes the block ignores
  localparam logic [2:0] CMD_SPARE_6 = 3'd6;
  localparam logic [2:0] CMD_SPARE_7 = 3'd7;

  // Burst flavours
  localparam int MODE_FILL  = 0;
  localparam int MODE_DRAIN = 1;
  localparam int MODE_MIXED = 2;

  logic               clk_i     = 1'b0;
  logic               rst_ni    = 1'b0;
  logic               start_i   = 1'b0;
  logic [2:0]         command_i = CMD_PUSH_FRONT;
  logic signed [31:0] value_i   = '0;
  logic               busy_o;
  logic               done_o;
  logic [1:0]         status_o;
  logic signed [31:0] removed_value_o;
  logic [4:0]         count_o;

  int fail_count;
  int pending;
  int checked;
  int full_hits;
  int empty_hits;
  int miss_hits;
  int sent_items;
  int stall_cycles;

  logic signed [31:0] value_pool[8];

  initial begin
    forever #5 clk_i = ~clk_i;
  end

  double_ended_queue #(
    .CAPACITY(CAPACITY)
  ) u_top (
    .clk_i          (clk_i),
    .rst_ni         (rst_ni),
    .start_i        (start_i),
    .busy_o         (busy_o),
    .command_i      (command_i),
    .value_i        (value_i),
    .done_o         (done_o),
    .status_o       (status_o),
    .removed_value_o(removed_value_o),
    .count_o        (count_o)
  );

  deque_checker #(
    .CAPACITY(CAPACITY)
  ) u_chk (
    .clk_i          (clk_i),
    .rst_ni         (rst_ni),
    .start_i        (start_i),
    .busy_o         (busy_o),
    .command_i      (command_i),
    .value_i        (value_i),
    .done_o         (done_o),
    .status_o       (status_o),
    .removed_value_o(removed_value_o),
    .count_o        (count_o),
    .fail_count_o   (fail_count),
    .pending_o      (pending),
    .checked_o      (checked),
    .full_hits_o    (full_hits),
    .empty_hits_o   (empty_hits),
    .miss_hits_o    (miss_hits)
  );

  // Watchdog: too long without an item or a result moving
  always @(posedge clk_i) begin
    if (rst_ni) begin
      if ((start_i && !busy_o) || done_o) begin
        stall_cycles <= 0;
      end else if (stall_cycles + 1 >= STALL_LIMIT) begin
        $display("[double_ended_queue] ERROR");
        $finish;
      end else begin
        stall_cycles <= stall_cycles + 1;
      end
    end
  end

  // Present one item and hold it until taken
  task automatic issue(input logic [2:0] cmd, input logic signed [31:0] val);
    start_i   <= 1'b1;
    command_i <= cmd;
    value_i   <= val;
    do @(posedge clk_i); while (busy_o);
    sent_items++;
  endtask

  task automatic hold_off(input int cycles);
    start_i <= 1'b0;
    repeat (cycles) @(posedge clk_i);
  endtask

  // Stop sending until every owed result is back
  task automatic wait_drained();
    start_i <= 1'b0;
    @(posedge clk_i);
    while (pending != 0) @(posedge clk_i);
  endtask

  // Pool values make removes hit; the rest are fully random
  function automatic logic signed [31:0] pick_value();
    if ($urandom_range(0, 9) < 6) return value_pool[$urandom_range(0, 7)];
    return $urandom();
  endfunction

  function automatic logic [2:0] pick_command(input int mode);
    int pick;
    int push_pct;
    pick = $urandom_range(0, 99);
    if (pick == 0) return CMD_SPARE_6;
    if (pick == 1) return CMD_SPARE_7;
    if (pick < 5) return CMD_CLEAR;
    case (mode)
      MODE_FILL:  push_pct = 75;
      MODE_DRAIN: push_pct = 30;
      default:    push_pct = 50;
    endcase
    if ($urandom_range(0, 99) < push_pct)
      return $urandom_range(0, 1) ? CMD_PUSH_BACK : CMD_PUSH_FRONT;
    case ($urandom_range(0, 2))
      0:       return CMD_POP_FRONT;
      1:       return CMD_POP_BACK;
      default: return CMD_REMOVE;
    endcase
  endfunction

  initial begin : stimulus
    logic signed [31:0] fill_val;
    logic [2:0]         cmd;
    int                 directed_items;
    int                 counted;
    int                 next_drain;
    int                 mode;

    value_pool[0] = 32'sh8000_0000;
    value_pool[1] = 32'sh7fff_ffff;
    value_pool[2] = -32'sd1;
    value_pool[3] = 32'sd0;
    for (int i = 4; i < 8; i++) value_pool[i] = $urandom();

    repeat (12) @(posedge clk_i);
    rst_ni <= 1'b1;

    // Directed: empty cases, fill with extremes and a duplicate, full pushes
    issue(CMD_POP_FRONT, 32'sd0);
    issue(CMD_POP_BACK, 32'sd0);
    issue(CMD_REMOVE, 32'sd0);
    for (int i = 0; i < CAPACITY; i++) begin
      case (i)
        0:       fill_val = 32'sh8000_0000;
        1:       fill_val = 32'sh7fff_ffff;
        2:       fill_val = -32'sd1;
        3:       fill_val = 32'sd0;
        4, 5:    fill_val = 32'sd7;
        default: fill_val = $urandom();
      endcase
      issue((i % 2) ? CMD_PUSH_BACK : CMD_PUSH_FRONT, fill_val);
    end
    issue(CMD_PUSH_FRONT, 32'sd11);
    issue(CMD_PUSH_BACK, 32'sd12);
    issue(CMD_REMOVE, 32'sd7);
    issue(CMD_REMOVE, 32'sh1234_5678);
    issue(CMD_POP_FRONT, 32'sd0);
    issue(CMD_POP_BACK, 32'sd0);
    issue(CMD_SPARE_6, $urandom());
    issue(CMD_SPARE_7, $urandom());
    issue(CMD_CLEAR, $urandom());
    directed_items = sent_items;
    wait_drained();

    // Random bursts; spare codes do not count towards the target
    counted    = 0;
    next_drain = DRAIN_EVERY;
    while (counted < ITEM_TARGET) begin
      mode = $urandom_range(MODE_FILL, MODE_MIXED);
      repeat ($urandom_range(1, 30)) begin
        cmd = pick_command(mode);
        issue(cmd, pick_value());
        if (cmd <= CMD_CLEAR) counted++;
      end
      if ($urandom_range(0, 9) == 0) value_pool[$urandom_range(4, 7)] = $urandom();
      if (counted >= next_drain) begin
        wait_drained();
        next_drain += DRAIN_EVERY;
      end else if ($urandom_range(0, 2) != 0) begin
        hold_off($urandom_range(1, 8));
      end
    end

    wait_drained();
    repeat (TAIL_CYCLES) @(posedge clk_i);

    $display("Sent %0d items (%0d directed) over all commands and spare codes; %0d results checked",
             sent_items, directed_items, checked);
    $display("Pushes into a full deque %0d, pops from empty %0d, removes with no match %0d",
             full_hits, empty_hits, miss_hits);
    if (fail_count == 0 && pending == 0) begin
      $display("[double_ended_queue] OK");
    end else begin
      $display("[double_ended_queue] ERROR");
    end
    $finish;
  end

endmodule
